@@ hw/rtl/pgai_pkg.sv @@
`timescale 1ns / 1ps

package pgai_pkg;

    localparam int KEY_ROWS_DEFAULT = 3;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_KEY   = 2'd3;

    localparam logic [7:0] OFS_LCD_DATA = 8'd4;
    localparam logic [7:0] OFS_LCD_CMD  = 8'd5;
    localparam logic [7:0] OFS_IRQ_ACK  = 8'd6;
    localparam logic [7:0] OFS_MASK     = 8'd7;

    localparam logic [1:0] STROBE_NONE = 2'd0;
    localparam logic [1:0] STROBE_DATA = 2'd1;
    localparam logic [1:0] STROBE_CMD  = 2'd2;

    localparam logic [7:0] READ_IDLE          = 8'hff;
    localparam logic [7:0] MASK_RESET         = 8'hff;
    localparam logic [7:0] SCAN_LATCH_RESET   = 8'hf7;
    localparam logic [7:0] KEY_RETURNS_RESET  = 8'hff;
    localparam logic [7:0] LCD_TICKS_RESET    = 8'd16;
    localparam logic [7:0] SRC_LCD_DONE       = 8'h01;
    localparam logic [7:0] SRC_RX_READY       = 8'h08;

    typedef struct packed {
        logic [1:0] action;
        logic [8:0] address;
        logic [7:0] write_data;
        logic [1:0] key_row;
        logic [2:0] key_bit;
        logic       key_down;
        logic       rx_ready;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       irq_dropped;
        logic [1:0] lcd_strobe;
        logic       lcd_supply;
        logic [2:0] lamps;
    } out_item_t;

    typedef struct packed {
        logic       en;
        logic [1:0] key_row;
        logic [2:0] key_bit;
        logic       key_down;
    } key_upd_t;

endpackage

@@ hw/rtl/pgai_keys.sv @@
`timescale 1ns / 1ps

module pgai_keys #(
    parameter int KEY_ROWS = pgai_pkg::KEY_ROWS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pgai_pkg::key_upd_t upd,
    input  logic [7:0]        scan_low,
    output logic [7:0]        scan_data
);
    import pgai_pkg::*;

    logic [7:0] key_returns_reg [KEY_ROWS];

    for (genvar r = 0; r < KEY_ROWS; r++) begin : g_row
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                key_returns_reg[r] <= KEY_RETURNS_RESET;
            end else if (upd.en && int'(upd.key_row) == r) begin
                key_returns_reg[r][upd.key_bit] <= !upd.key_down;
            end
        end
    end

    // a row takes part when its strobe bit is low
    always_comb begin
        scan_data = 8'hff;
        for (int r = 0; r < KEY_ROWS; r++) begin
            if (!scan_low[r]) begin
                scan_data = scan_data & key_returns_reg[r];
            end
        end
    end

endmodule

@@ hw/rtl/pgai_core.sv @@
`timescale 1ns / 1ps

module pgai_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  pgai_pkg::in_item_t  item,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic [7:0]          scan_data,
    output logic [7:0]          scan_low,
    output pgai_pkg::key_upd_t  key_upd,
    output pgai_pkg::out_item_t result
);
    import pgai_pkg::*;

    logic [7:0] lcd_ticks_reg;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] count_reg, count_next;
    logic       last_rx_reg, last_rx_next;

    logic [7:0] pend_rx;
    logic [7:0] active;
    logic [2:0] ack_idx;
    logic       in_scan;

    assign scan_low = item.address[7:0];
    assign in_scan  = !item.address[8];
    assign pend_rx  = pending_reg | ((item.rx_ready && !last_rx_reg) ? SRC_RX_READY : 8'h00);
    assign active   = pend_rx & ~mask_reg;

    // lowest enabled pending source
    always_comb begin
        ack_idx = 3'd0;
        for (int n = 7; n >= 0; n--) begin
            if (active[n]) begin
                ack_idx = 3'(n);
            end
        end
    end

    always_comb begin
        pending_next       = pending_reg;
        mask_next          = mask_reg;
        latch_next         = latch_reg;
        count_next         = count_reg;
        last_rx_next       = last_rx_reg;
        key_upd            = '0;
        result.read_data   = READ_IDLE;
        result.irq_dropped = 1'b0;
        result.lcd_strobe  = STROBE_NONE;
        if (fire) begin
            pending_next = pend_rx;
            last_rx_next = item.rx_ready;
            unique case (item.action)
                ACT_READ: begin
                    if (in_scan) begin
                        latch_next       = scan_low;
                        result.read_data = scan_data;
                    end else if (scan_low == OFS_IRQ_ACK) begin
                        if (active == 8'h00) begin
                            result.read_data = 8'h00;
                        end else begin
                            result.read_data   = {5'b0, ack_idx} + 8'd1;
                            result.irq_dropped = 1'b1;
                            pending_next       = pend_rx & ~(8'b1 << ack_idx);
                        end
                    end
                end
                ACT_WRITE: begin
                    if (in_scan) begin
                        latch_next = scan_low;
                    end else if (scan_low == OFS_LCD_DATA || scan_low == OFS_LCD_CMD) begin
                        result.lcd_strobe = (scan_low == OFS_LCD_DATA) ? STROBE_DATA
                                                                        : STROBE_CMD;
                        count_next = lcd_ticks_reg;
                    end else if (scan_low == OFS_MASK) begin
                        mask_next = item.write_data;
                    end
                end
                ACT_TICK: begin
                    if (count_reg != 8'd0) begin
                        count_next = count_reg - 8'd1;
                        if (count_reg == 8'd1) begin
                            pending_next = pend_rx | SRC_LCD_DONE;
                        end
                    end
                end
                ACT_KEY: begin
                    key_upd.en       = 1'b1;
                    key_upd.key_row  = item.key_row;
                    key_upd.key_bit  = item.key_bit;
                    key_upd.key_down = item.key_down;
                end
                default: begin
                end
            endcase
        end
        result.irq_request = |(pending_next & ~mask_next);
        result.lcd_supply  = latch_next[3];
        result.lamps       = ~latch_next[6:4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcd_ticks_reg <= LCD_TICKS_RESET;
            pending_reg   <= 8'h00;
            mask_reg      <= MASK_RESET;
            latch_reg     <= SCAN_LATCH_RESET;
            count_reg     <= 8'h00;
            last_rx_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lcd_ticks_reg <= cfg_wr_data;
            end
            pending_reg <= pending_next;
            mask_reg    <= mask_next;
            latch_reg   <= latch_next;
            count_reg   <= count_next;
            last_rx_reg <= last_rx_next;
        end
    end

endmodule

@@ hw/rtl/panel_gate_array_interrupt_scan.sv @@
`timescale 1ns / 1ps
// panel gate array: interrupt latch with priority acknowledge, lcd-done timer, key scan
// s_ channel: one item per bus read, bus write, frame tick or key change (valid/ready)
// m_ channel: exactly one result item per input item, in order (valid/ready)
// cfg_wr_en/cfg_wr_data: loads the lcd-done tick count; the user must write it while the block is idle, unchecked
// an accepted item sits in the input register until the output register can move;
// its state update and result are then taken into the output register, and the
// result is offered from there
// throughput is one item per cycle while m_ready is high: the single pass of priority
// encode and latch updates between the two registers sets it
// when m_ready is low the result holds and the input register takes one more item,
// then s_ready falls until the result is taken
// reset clears both registers and restores the sources, mask, scan latch, key rows,
// countdown and tick count to their idle values

module panel_gate_array_interrupt_scan #(
    parameter int KEY_ROWS = pgai_pkg::KEY_ROWS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pgai_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pgai_pkg::out_item_t m_item,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);
    import pgai_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      m_valid_reg;
    out_item_t m_item_reg;

    logic      advance;
    logic      fire;
    out_item_t result;
    key_upd_t  key_upd;
    logic [7:0] scan_low;
    logic [7:0] scan_data;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_item_reg <= s_item;
        end
        if (fire) begin
            m_item_reg <= result;
        end
    end

    pgai_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (in_item_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .scan_data   (scan_data),
        .scan_low    (scan_low),
        .key_upd     (key_upd),
        .result      (result)
    );

    pgai_keys #(
        .KEY_ROWS (KEY_ROWS)
    ) u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (key_upd),
        .scan_low  (scan_low),
        .scan_data (scan_data)
    );

`ifndef SYNTHESIS
    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the output register could move");

    a_ack_source_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.irq_dropped) |->
        (m_item.read_data != 8'd0 && m_item.read_data <= 8'd8))
        else $error("acknowledge returned no valid source number");

    a_strobe_not_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.lcd_strobe != STROBE_NONE) |->
        (m_item.read_data == READ_IDLE && !m_item.irq_dropped))
        else $error("lcd strobe on an item that read data");
`endif

endmodule
